// File: sv/bci_pkg.sv
`default_nettype none
package bci_pkg;

   // configuration register widths
   localparam int LINE_BITS   = 13;
   localparam int COLUMN_BITS = 12;
   localparam int BAND_BITS   = 6;
   localparam int ROW_BITS    = 12;
   localparam int ROWS_BITS   = 13;
   localparam int CSR_DATA_BITS = 13;
   localparam int CSR_INDEX_BITS = 3;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BAND_COLUMN = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BAND_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BAND_ROW    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BAND_ROWS   = 3'd4;

   // reset values
   localparam logic [LINE_BITS-1:0]   LINE_WIDTH_RESET  = 13'd4096;
   localparam logic [COLUMN_BITS-1:0] BAND_COLUMN_RESET = 12'd2;
   localparam logic [BAND_BITS-1:0]   BAND_WIDTH_RESET  = 6'd1;
   localparam logic [ROW_BITS-1:0]    BAND_ROW_RESET    = 12'd0;
   localparam logic [ROWS_BITS-1:0]   BAND_ROWS_RESET   = 13'd0;

   typedef enum logic [1:0] {
      ACT_PASS,
      ACT_HOLD,
      ACT_BURST
   } action_type;

endpackage
`default_nettype wire

// File: sv/bci_req_if.sv
`default_nettype none
interface bci_req_if #(
   parameter int PIXEL_BITS = 16
);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_in;
   logic                  frame_start;

   modport source (output valid, output pixel_in, output frame_start, input ready);
   modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface
`default_nettype wire

// File: sv/bci_rsp_if.sv
`default_nettype none
interface bci_rsp_if #(
   parameter int PIXEL_BITS = 16
);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_out;
   logic                  run_last;

   modport source (output valid, output pixel_out, output run_last, input ready);
   modport sink   (input valid, input pixel_out, input run_last, output ready);
endinterface
`default_nettype wire

// File: sv/bad_column_interpolation_unit.sv
`default_nettype none
// A passed pixel goes through the input stage and then the result stage to rsp.
// Throughput, while rsp is ready: one pixel per cycle; a corrected run emits
// band_width+2 results, one per cycle, from the single output register; req
// stalls on a blocked input stage. Band pixels and the first right neighbour
// produce no result of their own. Reset (synchronous, active high) restores
// register defaults, clears position, neighbour pixels and both pipeline stages.
module bad_column_interpolation_unit #(
   parameter int PIXEL_BITS = 16,
   parameter int MAX_LINE   = 4096,
   parameter int MAX_BAND   = 62
) (
   input  wire logic clock,
   input  wire logic reset,
   bci_req_if.sink   req_chan,
   bci_rsp_if.source rsp_chan,
   input  wire logic                                 csr_we,
   input  wire logic [bci_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [bci_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int COL_BITS = $clog2(MAX_LINE);
   localparam int CMP_BITS = ((COL_BITS > bci_pkg::LINE_BITS) ? COL_BITS
                                                               : bci_pkg::LINE_BITS) + 2;
   localparam int SUM_BITS = PIXEL_BITS + 2;

   // configuration
   logic [bci_pkg::LINE_BITS-1:0]   line_width_ff;
   logic [bci_pkg::COLUMN_BITS-1:0] band_column_ff;
   logic [bci_pkg::BAND_BITS-1:0]   band_width_ff;
   logic [bci_pkg::ROW_BITS-1:0]    band_row_ff;
   logic [bci_pkg::ROWS_BITS-1:0]   band_rows_ff;

   // position and neighbour pixels
   logic [COL_BITS-1:0]   col_ff, col_in;
   logic [COL_BITS-1:0]   row_ff, row_in;
   logic [PIXEL_BITS-1:0] left_far_ff, left_far_in;
   logic [PIXEL_BITS-1:0] left_near_ff, left_near_in;
   logic [PIXEL_BITS-1:0] right_near_ff, right_near_in;

   // input stage
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_burst_ff, s1_burst_in;
   logic [PIXEL_BITS-1:0] s1_pix_ff, s1_pix_in;

   // result stage
   logic                  o_valid_ff, o_valid_in;
   logic                  o_burst_ff, o_burst_in;
   logic [PIXEL_BITS-1:0] o_pix_ff, o_pix_in;
   logic [PIXEL_BITS-1:0] o_mean_ff, o_mean_in;
   logic [PIXEL_BITS-1:0] o_near_ff, o_near_in;
   logic [bci_pkg::BAND_BITS-1:0] o_idx_ff, o_idx_in;

   logic req_xfer, rsp_xfer, o_last, o_done, s1_move;
   logic [COL_BITS-1:0] cur_col, cur_row;
   logic [CMP_BITS-1:0] col_x, row_x, eff_x, bc_x, bw_x, br_x, brs_x;
   logic active;
   bci_pkg::action_type act;
   logic [SUM_BITS-1:0] sum;
   logic [bci_pkg::BAND_BITS:0] last_idx;

   // ---------------------------------------------------------------- classify
   always_comb begin
      cur_col = req_chan.frame_start ? '0 : col_ff;
      cur_row = req_chan.frame_start ? '0 : row_ff;
      col_x   = CMP_BITS'(cur_col);
      row_x   = CMP_BITS'(cur_row);
      eff_x   = (CMP_BITS'(line_width_ff) > CMP_BITS'(MAX_LINE)) ? CMP_BITS'(MAX_LINE)
                                                                : CMP_BITS'(line_width_ff);
      bc_x    = CMP_BITS'(band_column_ff);
      bw_x    = CMP_BITS'(band_width_ff);
      br_x    = CMP_BITS'(band_row_ff);
      brs_x   = CMP_BITS'(band_rows_ff);

      active = (bw_x != '0) && (bw_x <= CMP_BITS'(MAX_BAND)) && (bc_x >= CMP_BITS'(2))
               && (bc_x + bw_x + CMP_BITS'(1) < eff_x)
               && (row_x >= br_x) && (row_x < br_x + brs_x);

      act = bci_pkg::ACT_PASS;
      if (active) begin
         if (col_x >= bc_x && col_x <= bc_x + bw_x) begin
            act = bci_pkg::ACT_HOLD;
         end else if (col_x == bc_x + bw_x + CMP_BITS'(1)) begin
            act = bci_pkg::ACT_BURST;
         end
      end
   end

   // ---------------------------------------------------------------- handshakes
   assign last_idx = {1'b0, band_width_ff} + 1'b1;
   assign o_last   = !o_burst_ff || ({1'b0, o_idx_ff} == last_idx);
   assign rsp_xfer = rsp_chan.valid && rsp_chan.ready;
   assign o_done   = rsp_xfer && o_last;
   assign s1_move  = s1_valid_ff && (!o_valid_ff || o_done);
   assign req_chan.ready = !s1_valid_ff || s1_move;
   assign req_xfer = req_chan.valid && req_chan.ready;

   assign sum = SUM_BITS'(left_far_ff) + SUM_BITS'(left_near_ff)
              + SUM_BITS'(right_near_ff) + SUM_BITS'(s1_pix_ff);

   assign rsp_chan.valid    = o_valid_ff;
   assign rsp_chan.run_last = o_last;
   always_comb begin
      if (!o_burst_ff || ({1'b0, o_idx_ff} == last_idx)) begin
         rsp_chan.pixel_out = o_pix_ff;
      end else if (o_idx_ff == band_width_ff) begin
         rsp_chan.pixel_out = o_near_ff;
      end else begin
         rsp_chan.pixel_out = o_mean_ff;
      end
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      left_far_in   = left_far_ff;
      left_near_in  = left_near_ff;
      right_near_in = right_near_ff;
      s1_valid_in   = s1_valid_ff && !s1_move;
      s1_burst_in   = s1_burst_ff;
      s1_pix_in     = s1_pix_ff;

      if (req_xfer) begin
         if (active && col_x + CMP_BITS'(2) == bc_x) begin
            left_far_in = req_chan.pixel_in;
         end
         if (active && col_x + CMP_BITS'(1) == bc_x) begin
            left_near_in = req_chan.pixel_in;
         end
         if (active && col_x == bc_x + bw_x) begin
            right_near_in = req_chan.pixel_in;
         end
         // row end
         if (col_x + CMP_BITS'(1) >= eff_x) begin
            col_in = '0;
            row_in = (row_x + CMP_BITS'(1) == CMP_BITS'(MAX_LINE)) ? '0 : cur_row + 1'b1;
         end else begin
            col_in = cur_col + 1'b1;
            row_in = cur_row;
         end
         if (act != bci_pkg::ACT_HOLD) begin
            s1_valid_in = 1'b1;
            s1_burst_in = (act == bci_pkg::ACT_BURST);
            s1_pix_in   = req_chan.pixel_in;
         end
      end

      o_valid_in = o_valid_ff && !o_done;
      o_burst_in = o_burst_ff;
      o_pix_in   = o_pix_ff;
      o_mean_in  = o_mean_ff;
      o_near_in  = o_near_ff;
      o_idx_in   = o_idx_ff;
      if (rsp_xfer && !o_last) begin
         o_idx_in = o_idx_ff + 1'b1;
      end
      if (s1_move) begin
         o_valid_in = 1'b1;
         o_burst_in = s1_burst_ff;
         o_pix_in   = s1_pix_ff;
         o_mean_in  = sum[SUM_BITS-1:2];
         o_near_in  = right_near_ff;
         o_idx_in   = '0;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff  <= bci_pkg::LINE_WIDTH_RESET;
         band_column_ff <= bci_pkg::BAND_COLUMN_RESET;
         band_width_ff  <= bci_pkg::BAND_WIDTH_RESET;
         band_row_ff    <= bci_pkg::BAND_ROW_RESET;
         band_rows_ff   <= bci_pkg::BAND_ROWS_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         left_far_ff   <= '0;
         left_near_ff  <= '0;
         right_near_ff <= '0;
         s1_valid_ff   <= 1'b0;
         o_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               bci_pkg::CSR_LINE_WIDTH:  line_width_ff  <= csr_wdata[bci_pkg::LINE_BITS-1:0];
               bci_pkg::CSR_BAND_COLUMN: band_column_ff <= csr_wdata[bci_pkg::COLUMN_BITS-1:0];
               bci_pkg::CSR_BAND_WIDTH:  band_width_ff  <= csr_wdata[bci_pkg::BAND_BITS-1:0];
               bci_pkg::CSR_BAND_ROW:    band_row_ff    <= csr_wdata[bci_pkg::ROW_BITS-1:0];
               bci_pkg::CSR_BAND_ROWS:   band_rows_ff   <= csr_wdata[bci_pkg::ROWS_BITS-1:0];
               default: ;
            endcase
         end
         col_ff        <= col_in;
         row_ff        <= row_in;
         left_far_ff   <= left_far_in;
         left_near_ff  <= left_near_in;
         right_near_ff <= right_near_in;
         s1_valid_ff   <= s1_valid_in;
         o_valid_ff    <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_burst_ff <= s1_burst_in;
      s1_pix_ff   <= s1_pix_in;
      o_burst_ff  <= o_burst_in;
      o_pix_ff    <= o_pix_in;
      o_mean_ff   <= o_mean_in;
      o_near_ff   <= o_near_in;
      o_idx_ff    <= o_idx_in;
   end

   // ---------------------------------------------------------------- checks
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      o_valid_ff && o_burst_ff |-> ({1'b0, o_idx_ff} <= last_idx))
      else $error("burst index past last result");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(s1_pix_ff) && $stable(s1_burst_ff))
      else $error("input stage overwritten while blocked");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> s1_valid_ff && o_valid_ff)
      else $error("req stalled with a free stage");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !o_valid_ff && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_pass_single: assert property (@(posedge clock) disable iff (reset)
      o_valid_ff && !o_burst_ff |-> o_last)
      else $error("passed pixel not marked last");

endmodule
`default_nettype wire

// File: tb/tb_bad_column_interpolation_unit.sv
`timescale 1ns / 1ps
module tb_bad_column_interpolation_unit;

   localparam int LINE_LIMIT   = 4096;
   localparam int BAND_LIMIT   = 62;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 300;
   localparam int SCRIPT_LEN   = 30;
   localparam int DATA_BITS    = bci_pkg::CSR_DATA_BITS;

   typedef enum logic {STEP_PIXEL, STEP_CSR} step_kind_type;

   typedef struct packed {
      logic [15:0] pix;
      logic        last;
   } out_pixel_type;

   typedef struct packed {
      step_kind_type                      kind;
      logic [bci_pkg::CSR_INDEX_BITS-1:0] index;
      logic [bci_pkg::CSR_DATA_BITS-1:0]  value;
      logic [15:0]                        pix;
      logic                               fs;
      logic                               known;
      logic [15:0]                        known_pix;
      logic                               known_last;
   } step_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [bci_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [bci_pkg::CSR_DATA_BITS-1:0]  csr_wdata;

   bci_req_if #(.PIXEL_BITS(16)) req_bus ();
   bci_rsp_if #(.PIXEL_BITS(16)) rsp_bus ();

   bad_column_interpolation_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of the registers and the stream position
   logic [bci_pkg::LINE_BITS-1:0]   cfg_line  = bci_pkg::LINE_WIDTH_RESET;
   logic [bci_pkg::COLUMN_BITS-1:0] cfg_col   = bci_pkg::BAND_COLUMN_RESET;
   logic [bci_pkg::BAND_BITS-1:0]   cfg_width = bci_pkg::BAND_WIDTH_RESET;
   logic [bci_pkg::ROW_BITS-1:0]    cfg_row   = bci_pkg::BAND_ROW_RESET;
   logic [bci_pkg::ROWS_BITS-1:0]   cfg_rows  = bci_pkg::BAND_ROWS_RESET;
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;
   logic [15:0] far_left   = '0;
   logic [15:0] near_left  = '0;
   logic [15:0] near_right = '0;

   out_pixel_type pixels_due [$];
   out_pixel_type emitted [$];
   out_pixel_type due;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned random_pixels = 0;
   bit no_gaps = 1'b0;
   step_type script [SCRIPT_LEN];

   function automatic void correct_pixel(input logic [15:0] pix, input logic fs);
      int unsigned eff, bc, bw, row_lo, row_hi;
      logic active;
      logic [17:0] sum;
      emitted.delete();
      if (fs) begin
         col_pos = 0;
         row_pos = 0;
      end
      eff    = (cfg_line > LINE_LIMIT) ? LINE_LIMIT : cfg_line;
      bc     = cfg_col;
      bw     = cfg_width;
      row_lo = cfg_row;
      row_hi = row_lo + cfg_rows;
      active = bw >= 1 && bw <= BAND_LIMIT && bc >= 2 && bc + bw + 1 < eff
               && row_pos >= row_lo && row_pos < row_hi;
      if (!active) begin
         emitted.push_back(out_pixel_type'{pix, 1'b1});
      end else if (col_pos == bc - 2) begin
         far_left = pix;
         emitted.push_back(out_pixel_type'{pix, 1'b1});
      end else if (col_pos == bc - 1) begin
         near_left = pix;
         emitted.push_back(out_pixel_type'{pix, 1'b1});
      end else if (col_pos >= bc && col_pos < bc + bw) begin
         // band pixel, dropped
      end else if (col_pos == bc + bw) begin
         near_right = pix;
      end else if (col_pos == bc + bw + 1) begin
         sum = 18'(far_left) + 18'(near_left) + 18'(near_right) + 18'(pix);
         for (int unsigned i = 0; i < bw; i++)
            emitted.push_back(out_pixel_type'{sum[17:2], 1'b0});
         emitted.push_back(out_pixel_type'{near_right, 1'b0});
         emitted.push_back(out_pixel_type'{pix, 1'b1});
      end else begin
         emitted.push_back(out_pixel_type'{pix, 1'b1});
      end
      if (col_pos + 1 >= eff) begin
         col_pos = 0;
         row_pos = (row_pos + 1) % LINE_LIMIT;
      end else begin
         col_pos = col_pos + 1;
      end
   endfunction

   function automatic step_type csr_step(input logic [bci_pkg::CSR_INDEX_BITS-1:0] index,
                                         input logic [bci_pkg::CSR_DATA_BITS-1:0] value);
      step_type s;
      s = '0;
      s.kind  = STEP_CSR;
      s.index = index;
      s.value = value;
      return s;
   endfunction

   function automatic step_type pixel_step(input logic [15:0] pix, input logic fs);
      step_type s;
      s = '0;
      s.kind = STEP_PIXEL;
      s.pix  = pix;
      s.fs   = fs;
      return s;
   endfunction

   function automatic step_type known_step(input logic [15:0] pix, input logic fs,
                                           input logic [15:0] known_pix,
                                           input logic known_last);
      step_type s;
      s = pixel_step(pix, fs);
      s.known      = 1'b1;
      s.known_pix  = known_pix;
      s.known_last = known_last;
      return s;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatches++;
   endtask

   // one pixel transfer; returns at the accepting rising edge
   task automatic push_pixel(input logic [15:0] pix, input logic fs, input logic known,
                             input logic [15:0] known_pix, input logic known_last);
      @(negedge clock);
      while (!no_gaps && $urandom_range(0, 99) < 21) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.pixel_in    <= pix;
      req_bus.frame_start <= fs;
      do @(posedge clock); while (!req_bus.ready);
      correct_pixel(pix, fs);
      if (known)
         pixels_due.push_back(out_pixel_type'{known_pix, known_last});
      else
         foreach (emitted[i]) pixels_due.push_back(emitted[i]);
   endtask

   task automatic drain(input int unsigned settle);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pixels_due.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_reg(input logic [bci_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [bci_pkg::CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         bci_pkg::CSR_LINE_WIDTH:  cfg_line  = value[bci_pkg::LINE_BITS-1:0];
         bci_pkg::CSR_BAND_COLUMN: cfg_col   = value[bci_pkg::COLUMN_BITS-1:0];
         bci_pkg::CSR_BAND_WIDTH:  cfg_width = value[bci_pkg::BAND_BITS-1:0];
         bci_pkg::CSR_BAND_ROW:    cfg_row   = value[bci_pkg::ROW_BITS-1:0];
         bci_pkg::CSR_BAND_ROWS:   cfg_rows  = value[bci_pkg::ROWS_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(input int unsigned lw, bc, bw, brow, brows, n,
                            input bit pause_midway);
      logic [15:0] pix;
      int unsigned pick;
      drain(4);
      write_reg(bci_pkg::CSR_LINE_WIDTH,  DATA_BITS'(lw));
      write_reg(bci_pkg::CSR_BAND_COLUMN, DATA_BITS'(bc));
      write_reg(bci_pkg::CSR_BAND_WIDTH,  DATA_BITS'(bw));
      write_reg(bci_pkg::CSR_BAND_ROW,    DATA_BITS'(brow));
      write_reg(bci_pkg::CSR_BAND_ROWS,   DATA_BITS'(brows));
      for (int unsigned i = 0; i < n; i++) begin
         if (pause_midway && i == n / 2)
            drain(0);
         pick = $urandom_range(0, 9);
         pix  = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
         // occasional frame start mid-frame breaks a pending run
         push_pixel(pix, i == 0 || $urandom_range(0, 99) < 3, 1'b0, '0, 1'b0);
         random_pixels++;
      end
   endtask

   always @(negedge clock)
      rsp_bus.ready <= no_gaps || ($urandom_range(0, 99) >= 21);

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pixels_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected result pixel %h last %b",
                                    rsp_bus.pixel_out, rsp_bus.run_last));
         end else begin
            due = pixels_due.pop_front();
            if (rsp_bus.pixel_out !== due.pix)
               flag_mismatch($sformatf("pixel_out %h, expected %h", rsp_bus.pixel_out, due.pix));
            if (rsp_bus.run_last !== due.last)
               flag_mismatch($sformatf("run_last %b, expected %b", rsp_bus.run_last, due.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_bad_column_interpolation_unit: done, errors");
         $finish;
      end
   end

   initial begin
      int unsigned lw, bc, bw, brow, brows, n, phase, eff;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.pixel_in    = '0;
      req_bus.frame_start = 1'b0;
      rsp_bus.ready       = 1'b0;
      csr_we              = 1'b0;
      csr_index           = bci_pkg::CSR_LINE_WIDTH;
      csr_wdata           = '0;

      script = '{
         // reset settings leave correction off
         known_step(16'h0000, 1'b1, 16'h0000, 1'b1),
         known_step(16'hFFFF, 1'b0, 16'hFFFF, 1'b1),
         known_step(16'h8000, 1'b0, 16'h8000, 1'b1),
         csr_step(bci_pkg::CSR_LINE_WIDTH, 13'd8),
         csr_step(bci_pkg::CSR_BAND_ROWS, 13'd1),
         // full-scale neighbours, sum wider than a pixel
         pixel_step(16'hFFFF, 1'b1),
         pixel_step(16'hFFFF, 1'b0),
         pixel_step(16'h1234, 1'b0),
         pixel_step(16'hFFFF, 1'b0),
         pixel_step(16'hFFFF, 1'b0),
         pixel_step(16'h0001, 1'b0),
         pixel_step(16'h0002, 1'b0),
         pixel_step(16'h0003, 1'b0),
         // second row is outside the corrected rows
         known_step(16'hAAAA, 1'b0, 16'hAAAA, 1'b1),
         // frame start drops a half-collected run
         pixel_step(16'h0000, 1'b1),
         pixel_step(16'h0000, 1'b0),
         pixel_step(16'h5555, 1'b0),
         pixel_step(16'h7777, 1'b1),
         pixel_step(16'h0003, 1'b0),
         pixel_step(16'hFFFF, 1'b0),
         pixel_step(16'h0001, 1'b0),
         pixel_step(16'h0002, 1'b0),
         // right neighbour would fall off the row
         csr_step(bci_pkg::CSR_BAND_WIDTH, 13'd5),
         known_step(16'h0102, 1'b1, 16'h0102, 1'b1),
         known_step(16'h0304, 1'b0, 16'h0304, 1'b1),
         known_step(16'h0506, 1'b0, 16'h0506, 1'b1),
         csr_step(bci_pkg::CSR_BAND_WIDTH, 13'd0),
         known_step(16'hFFFF, 1'b1, 16'hFFFF, 1'b1),
         csr_step(bci_pkg::CSR_LINE_WIDTH, 13'd1),
         known_step(16'h0001, 1'b1, 16'h0001, 1'b1)
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == STEP_CSR) begin
            drain(4);
            write_reg(script[i].index, script[i].value);
         end else begin
            push_pixel(script[i].pix, script[i].fs, script[i].known,
                       script[i].known_pix, script[i].known_last);
         end
      end

      // widest band with no idling on either side, then the narrowest line
      // and the top register values
      no_gaps = 1'b1;
      run_phase(66, 2, BAND_LIMIT, 0, 4096, 134, 1'b0);
      no_gaps = 1'b0;
      run_phase(4, 4093, 1, 4095, 0, 12, 1'b0);
      run_phase(4096, 2, 1, 0, 1, 30, 1'b0);

      phase = 0;
      while (random_pixels < RANDOM_ITEMS) begin
         no_gaps = (phase == 1);
         if ($urandom_range(0, 99) < 80) begin
            lw = $urandom_range(5, 40);
            if ($urandom_range(0, 9) == 0)
               lw = $urandom_range(41, 80);
            bw    = $urandom_range(1, (lw - 4 > BAND_LIMIT) ? BAND_LIMIT : lw - 4);
            bc    = $urandom_range(2, lw - bw - 2);
            brow  = $urandom_range(0, 2);
            brows = $urandom_range(0, 4);
         end else begin
            // settings that break the band or the line
            lw    = $urandom_range(0, 20);
            bc    = $urandom_range(0, 12);
            bw    = $urandom_range(0, 63);
            brow  = $urandom_range(0, 2);
            brows = $urandom_range(0, 8191);
            if ($urandom_range(0, 3) == 0) begin
               lw   = $urandom_range(4097, 8191);
               bc   = $urandom_range(0, 4095);
               brow = $urandom_range(0, 4095);
            end
         end
         eff = (lw == 0) ? 1 : (lw > LINE_LIMIT) ? LINE_LIMIT : lw;
         n = eff * $urandom_range(2, 3);
         if (n > 90) n = 90;
         if (n < 8) n = 8;
         run_phase(lw, bc, bw, brow, brows, n, phase == 2);
         phase++;
      end
      no_gaps = 1'b0;

      drain(10);
      if (mismatches == 0)
         $display("tb_bad_column_interpolation_unit: done, clean");
      else
         $display("tb_bad_column_interpolation_unit: done, errors");
      $finish;
   end

endmodule
